// File: rtl/hvd_pkg.sv
// Shared types, constants and arithmetic steps for the haversine distance block.
`timescale 1ns / 1ps
`default_nettype none
package hvd_pkg;

	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [63:0] HALF_DEG180 = 64'd1509949440;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [23:0] RADIUS_RESET = 24'd1630976;

	// degree to radian conversion: product, reciprocal product, remainder
	localparam int CONV_STAGES = 3;
	localparam int SQRT_STEPS = 31;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// angles reduced to [0, 90] degrees, Q24, ready for the trig lanes
	typedef struct packed {
		logic [30:0] m_dlat;
		logic [30:0] m_dlon;
		logic [30:0] m_lat_a;
		logic [30:0] m_lat_b;
		logic        neg_a;
		logic        neg_b;
	} hvd_angles_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} cordic_t;

	typedef struct packed {
		logic [60:0] n;
		logic [60:0] r;
	} sqrt_t;

	function automatic logic signed [33:0] atan_q30(logic [4:0] i);
		logic signed [33:0] a;
		unique case (i)
			5'd0:  a = 34'sh03243F6A8;
			5'd1:  a = 34'sh01DAC6705;
			5'd2:  a = 34'sh00FADBAFC;
			5'd3:  a = 34'sh007F56EA6;
			5'd4:  a = 34'sh003FEAB76;
			5'd5:  a = 34'sh001FFD55B;
			5'd6:  a = 34'sh000FFFAAA;
			5'd7:  a = 34'sh0007FFF55;
			5'd8:  a = 34'sh0003FFFEA;
			5'd9:  a = 34'sh0001FFFFD;
			5'd10: a = 34'sh0000FFFFF;
			5'd11: a = 34'sh00007FFFF;
			5'd12: a = 34'sh00003FFFF;
			5'd13: a = 34'sh00001FFFF;
			5'd14: a = 34'sh00000FFFF;
			5'd15: a = 34'sh000007FFF;
			5'd16: a = 34'sh000003FFF;
			5'd17: a = 34'sh000001FFF;
			5'd18: a = 34'sh000000FFF;
			5'd19: a = 34'sh0000007FF;
			5'd20: a = 34'sh0000003FF;
			5'd21: a = 34'sh0000001FF;
			5'd22: a = 34'sh0000000FF;
			5'd23: a = 34'sh00000007F;
			5'd24: a = 34'sh00000003F;
			5'd25: a = 34'sh00000001F;
			5'd26: a = 34'sh00000000F;
			5'd27: a = 34'sh000000008;
			5'd28: a = 34'sh000000004;
			5'd29: a = 34'sh000000002;
			5'd30: a = 34'sh000000001;
			5'd31: a = 34'sh000000000;
		endcase
		return a;
	endfunction

	// Q30 x Q30 product, rounded half up
	function automatic logic signed [31:0] mul_q30(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd536870912;
		return p[61:30];
	endfunction

	// rotation mode micro-rotation
	function automatic cordic_t cordic_rot(cordic_t s, logic [4:0] i);
		cordic_t r;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		dx = s.y >>> i;
		dy = s.x >>> i;
		if (!s.z[33]) begin
			r.x = s.x - dx;
			r.y = s.y + dy;
			r.z = s.z - atan_q30(i);
		end else begin
			r.x = s.x + dx;
			r.y = s.y - dy;
			r.z = s.z + atan_q30(i);
		end
		return r;
	endfunction

	// vectoring mode micro-rotation
	function automatic cordic_t cordic_vec(cordic_t s, logic [4:0] i);
		cordic_t r;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		dx = s.y >>> i;
		dy = s.x >>> i;
		if (!s.y[33]) begin
			r.x = s.x + dx;
			r.y = s.y - dy;
			r.z = s.z + atan_q30(i);
		end else begin
			r.x = s.x - dx;
			r.y = s.y + dy;
			r.z = s.z - atan_q30(i);
		end
		return r;
	endfunction

	// one digit of the bitwise integer square root, test bit 2^(60-2k)
	function automatic sqrt_t sqrt_step(sqrt_t s, logic [4:0] k);
		sqrt_t r;
		logic [60:0] bit_v;
		logic [60:0] sum;
		bit_v = 61'd1 << (7'd60 - 7'({k, 1'b0}));
		sum = s.r + bit_v;
		if (s.n >= sum) begin
			r.n = s.n - sum;
			r.r = (s.r >> 1) + bit_v;
		end else begin
			r.n = s.n;
			r.r = s.r >> 1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/hvd_pt_if.sv
// Input channel: a pair of points with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface hvd_pt_if;
	logic              valid;
	logic              ready;
	logic signed [30:0] lat_a;
	logic signed [31:0] lon_a;
	logic signed [30:0] lat_b;
	logic signed [31:0] lon_b;

	modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
		input ready);
	modport sink (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
		output ready);
endinterface
`default_nettype wire

// File: rtl/hvd_dist_if.sv
// Output channel: one distance with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface hvd_dist_if;
	logic        valid;
	logic        ready;
	logic [33:0] distance_q16;

	modport source (output valid, output distance_q16, input ready);
	modport sink (input valid, input distance_q16, output ready);
endinterface
`default_nettype wire

// File: rtl/hvd_front.sv
// Front end: takes point pairs, forms half differences and reduces all angles to [0, 90] deg.
`timescale 1ns / 1ps
`default_nettype none
module hvd_front
	import hvd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hvd_pt_if.sink     points,
	output logic       push,
	output hvd_angles_t push_data,
	input  wire logic  full
);

	localparam logic signed [35:0] H180 = 36'sd3019898880;
	localparam logic signed [35:0] H90  = 36'sd1509949440;
	localparam logic [32:0] C90  = 33'd1509949440;
	localparam logic [32:0] C180 = 33'd3019898880;
	localparam logic [32:0] C270 = 33'd4529848320;
	localparam logic [32:0] C360 = 33'd6039797760;

	// floor mod 180 deg, then fold onto [0, 90]; sin^2 is unchanged
	function automatic logic [30:0] half_fold(logic signed [35:0] h);
		logic signed [35:0] r;
		priority if (h < -H180) r = h + H180 + H180;
		else if (h < 0)         r = h + H180;
		else if (h >= H180)     r = h - H180;
		else                    r = h;
		if (r > H90)
			r = H180 - r;
		return r[30:0];
	endfunction

	// fold [0, 360) onto [0, 90] with a sign for the cosine
	function automatic logic [31:0] cos_fold(logic [32:0] m);
		logic [32:0] r;
		logic        neg;
		priority if (m <= C90) begin
			neg = 1'b0;
			r = m;
		end else if (m <= C180) begin
			neg = 1'b1;
			r = C180 - m;
		end else if (m < C270) begin
			neg = 1'b1;
			r = m - C180;
		end else begin
			neg = 1'b0;
			r = C360 - m;
		end
		return {neg, r[30:0]};
	endfunction

	logic              en;
	logic              v_s1;
	logic              v_s2;
	logic signed [31:0] hlat_s1;
	logic signed [32:0] hlon_s1;
	logic [32:0]        ga_s1;
	logic [32:0]        gb_s1;
	logic signed [31:0] hlat_c;
	logic signed [32:0] hlon_c;
	logic signed [33:0] ga_c;
	logic signed [33:0] gb_c;
	logic [31:0]        fa_c;
	logic [31:0]        fb_c;
	hvd_angles_t        ang_s2;

	assign en = !v_s2 || !full;
	assign points.ready = en;

	assign hlat_c = $signed({points.lat_b[30], points.lat_b})
		- $signed({points.lat_a[30], points.lat_a});
	assign hlon_c = $signed({points.lon_b[31], points.lon_b})
		- $signed({points.lon_a[31], points.lon_a});
	assign ga_c = $signed({{2{points.lat_a[30]}}, points.lat_a, 1'b0});
	assign gb_c = $signed({{2{points.lat_b[30]}}, points.lat_b, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= points.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hlat_s1 <= hlat_c;
			hlon_s1 <= hlon_c;
			ga_s1 <= ga_c[33] ? 33'(ga_c + 34'sd6039797760) : ga_c[32:0];
			gb_s1 <= gb_c[33] ? 33'(gb_c + 34'sd6039797760) : gb_c[32:0];
		end
	end

	assign fa_c = cos_fold(ga_s1);
	assign fb_c = cos_fold(gb_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s2.m_dlat <= half_fold(36'(hlat_s1));
			ang_s2.m_dlon <= half_fold(36'(hlon_s1));
			ang_s2.m_lat_a <= fa_c[30:0];
			ang_s2.m_lat_b <= fb_c[30:0];
			ang_s2.neg_a <= fa_c[31];
			ang_s2.neg_b <= fb_c[31];
		end
	end

	assign push = v_s2 && !full;
	assign push_data = ang_s2;

endmodule
`default_nettype wire

// File: rtl/hvd_fifo.sv
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module hvd_fifo
	import hvd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  hvd_angles_t wdata,
	output logic        full,
	input  wire logic   pop,
	output hvd_angles_t rdata,
	output logic        empty
);

	hvd_angles_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_AW:0]     cnt_q;

	assign full = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule
`default_nettype wire

// File: rtl/hvd_trig.sv
// Trig lane: degrees to radians (reciprocal multiply, remainder correction), then rotation CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module hvd_trig
	import hvd_pkg::*;
#(
	parameter int ITERS = 24
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [30:0]  m,
	output logic signed [31:0] sin_q30,
	output logic signed [31:0] cos_q30
);

	// floor(2^31 * pi_q30 / 180deg_q24) = floor(32 * pi_q30 / 45)
	localparam logic [31:0] RECIP_K   = 32'd2398762258;
	localparam logic [31:0] DEG180    = 32'd3019898880;
	localparam logic [33:0] DEG180_X2 = 34'd6039797760;

	logic [63:0] p_s1;
	logic [30:0] qa_s1;
	logic [63:0] p_s2;
	logic [62:0] qd_s2;
	logic [30:0] qa_s2;
	logic [33:0] r_s3;
	logic [30:0] qa_s3;
	logic [61:0] mk_c;
	logic [30:0] q_c;
	cordic_t     rot_s [ITERS];
	cordic_t     rot_in;

	// quotient of (m * pi + 90 deg) / 180 deg: the reciprocal estimate is
	// low by at most two, the remainder against 180 and 360 deg fixes it
	assign mk_c = 62'(m) * 62'(RECIP_K);
	assign q_c = qa_s3 + 31'(r_s3 >= 34'(DEG180)) + 31'(r_s3 >= DEG180_X2);

	assign rot_in.x = GAIN_Q30;
	assign rot_in.y = '0;
	assign rot_in.z = {3'd0, q_c};

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= 64'(m) * 64'(PI_Q30) + HALF_DEG180;
			qa_s1 <= mk_c[61:31];
			p_s2 <= p_s1;
			qa_s2 <= qa_s1;
			qd_s2 <= 63'(qa_s1) * 63'(DEG180);
			r_s3 <= 34'(p_s2 - 64'(qd_s2));
			qa_s3 <= qa_s2;
			rot_s[0] <= cordic_rot(rot_in, 5'd0);
			for (int k = 1; k < ITERS; k++)
				rot_s[k] <= cordic_rot(rot_s[k-1], 5'(k));
		end
	end

	assign sin_q30 = rot_s[ITERS-1].y[31:0];
	assign cos_q30 = rot_s[ITERS-1].x[31:0];

endmodule
`default_nettype wire

// File: rtl/hvd_back.sv
// Back end: trig lanes, haversine sum, two square roots, arc CORDIC and radius scaling.
`timescale 1ns / 1ps
`default_nettype none
module hvd_back
	import hvd_pkg::*;
#(
	parameter int ITERS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  hvd_angles_t      head,
	output logic             pop,
	input  wire logic [23:0] radius,
	hvd_dist_if.source       result
);

	localparam int TRIG_LAT = CONV_STAGES + ITERS;
	localparam int BACK_LAT = TRIG_LAT + 4 + SQRT_STEPS + 1 + SQRT_STEPS + ITERS + 1;

	logic              en;
	logic              vld_s [BACK_LAT];
	logic [1:0]        neg_s [TRIG_LAT];
	logic signed [31:0] sin_dlat;
	logic signed [31:0] sin_dlon;
	logic signed [31:0] cos_a;
	logic signed [31:0] cos_b;
	logic signed [31:0] cos_dlat;
	logic signed [31:0] cos_dlon;
	logic signed [31:0] sin_a;
	logic signed [31:0] sin_b;

	logic signed [31:0] s0_p1, s1_p1, ca_p1, cb_p1;
	logic signed [31:0] u2_p2, v2_p2, cc_p2;
	logic signed [31:0] u2_p3, t_p3;
	logic [30:0]        a_p4;
	logic signed [32:0] sum_c;

	sqrt_t       sqa_s [SQRT_STEPS];
	sqrt_t       sqb_s [SQRT_STEPS];
	logic [30:0] sb_s  [SQRT_STEPS];
	sqrt_t       sqa_in;
	sqrt_t       sqb_in;
	logic [30:0] s_q1;
	logic [60:0] n2_q1;
	logic [30:0] s_c;
	logic [61:0] ssq_c;

	cordic_t     vec_s [ITERS];
	cordic_t     vec_in;
	logic [30:0] theta_c;
	logic [55:0] prod_c;
	logic [33:0] dist_q;

	assign en = !result.valid || result.ready;
	assign pop = en && !empty;

	hvd_trig #(.ITERS(ITERS)) u_lane_dlat (
		.clk(clk), .en(en), .m(head.m_dlat), .sin_q30(sin_dlat), .cos_q30(cos_dlat));
	hvd_trig #(.ITERS(ITERS)) u_lane_dlon (
		.clk(clk), .en(en), .m(head.m_dlon), .sin_q30(sin_dlon), .cos_q30(cos_dlon));
	hvd_trig #(.ITERS(ITERS)) u_lane_lat_a (
		.clk(clk), .en(en), .m(head.m_lat_a), .sin_q30(sin_a), .cos_q30(cos_a));
	hvd_trig #(.ITERS(ITERS)) u_lane_lat_b (
		.clk(clk), .en(en), .m(head.m_lat_b), .sin_q30(sin_b), .cos_q30(cos_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BACK_LAT; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= !empty;
			for (int k = 1; k < BACK_LAT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	assign sum_c = 33'(u2_p3) + 33'(t_p3);

	// only sines of the half differences and cosines of the latitudes are used
	assign sqa_in.n = 61'(a_p4) << 30;
	assign sqa_in.r = '0;
	assign s_c = sqa_s[SQRT_STEPS-1].r[30:0];
	assign ssq_c = 62'(s_c) * 62'(s_c);
	assign sqb_in.n = n2_q1;
	assign sqb_in.r = '0;

	assign vec_in.x = 34'(sqb_s[SQRT_STEPS-1].r[30:0]);
	assign vec_in.y = 34'(sb_s[SQRT_STEPS-1]);
	assign vec_in.z = '0;

	assign theta_c = vec_s[ITERS-1].z[33] ? 31'd0 : vec_s[ITERS-1].z[30:0];
	assign prod_c = 56'(radius) * 56'(theta_c) + 56'd1048576;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= {head.neg_b, head.neg_a};
			for (int k = 1; k < TRIG_LAT; k++)
				neg_s[k] <= neg_s[k-1];

			s0_p1 <= sin_dlat;
			s1_p1 <= sin_dlon;
			ca_p1 <= neg_s[TRIG_LAT-1][0] ? -cos_a : cos_a;
			cb_p1 <= neg_s[TRIG_LAT-1][1] ? -cos_b : cos_b;

			u2_p2 <= mul_q30(s0_p1, s0_p1);
			v2_p2 <= mul_q30(s1_p1, s1_p1);
			cc_p2 <= mul_q30(ca_p1, cb_p1);

			u2_p3 <= u2_p2;
			t_p3 <= mul_q30(cc_p2, v2_p2);

			priority if (sum_c[32])
				a_p4 <= '0;
			else if (sum_c > 33'sd1073741824)
				a_p4 <= 31'd1073741824;
			else
				a_p4 <= sum_c[30:0];

			sqa_s[0] <= sqrt_step(sqa_in, 5'd0);
			for (int k = 1; k < SQRT_STEPS; k++)
				sqa_s[k] <= sqrt_step(sqa_s[k-1], 5'(k));

			s_q1 <= s_c;
			n2_q1 <= 61'((62'd1 << 60) - ssq_c);

			sqb_s[0] <= sqrt_step(sqb_in, 5'd0);
			sb_s[0] <= s_q1;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				sqb_s[k] <= sqrt_step(sqb_s[k-1], 5'(k));
				sb_s[k] <= sb_s[k-1];
			end

			vec_s[0] <= cordic_vec(vec_in, 5'd0);
			for (int k = 1; k < ITERS; k++)
				vec_s[k] <= cordic_vec(vec_s[k-1], 5'(k));

			dist_q <= prod_c[54:21];
		end
	end

	assign result.valid = vld_s[BACK_LAT-1];
	assign result.distance_q16 = dist_q;

endmodule
`default_nettype wire

// File: rtl/haversine_distance_top.sv
// Top level of the haversine great-circle distance block.
//
// Channels: points (sink) carries lat_a, lat_b in signed Q8.23 and lon_a, lon_b in
// signed Q9.23 degrees; result (source) carries distance_q16, unsigned Q18.16 in radius
// units. A transaction moves when valid and ready are both high. cfg_we/cfg_wdata write
// the sphere radius (unsigned Q16.8); write it only while no transaction is in flight.
// Throughput: one transaction per cycle while result is ready. Every stage is pipelined:
// four trig lanes (three-stage degree conversion by reciprocal multiply and remainder
// correction, then TRIG_ITERATIONS CORDIC rotations), two 31-stage bitwise square
// roots and a vectoring CORDIC.
// Stall: when result is held off, the back pipeline freezes; the front end keeps
// accepting into its two stages and a four-entry queue, then drops points.ready.
// Reset: arst_n clears all valid state and loads the radius with 6371.0 (1630976).
// No results are issued until points arrive.
`timescale 1ns / 1ps
`default_nettype none
module haversine_distance_top
	import hvd_pkg::*;
#(
	parameter int TRIG_ITERATIONS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata,
	hvd_pt_if.sink           points,
	hvd_dist_if.source       result
);

	logic [23:0] radius_q;
	logic        push;
	logic        full;
	logic        pop;
	logic        empty;
	hvd_angles_t push_data;
	hvd_angles_t head;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= RADIUS_RESET;
		else if (cfg_we)
			radius_q <= cfg_wdata;
	end

	// front: angle differences and range folding
	hvd_front u_front (
		.clk(clk), .arst_n(arst_n), .points(points),
		.push(push), .push_data(push_data), .full(full));

	// decoupling queue
	hvd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(push_data), .full(full),
		.pop(pop), .rdata(head), .empty(empty));

	// back: trig, sqrt, asin and scaling
	hvd_back #(.ITERS(TRIG_ITERATIONS)) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.radius(radius_q), .result(result));

endmodule
`default_nettype wire

// File: rtl/hvd_chk.sv
// Port-level checks for the haversine distance block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hvd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [33:0] distance_q16
);

	logic [15:0] cnt_q;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + 16'(in_valid && in_ready) - 16'(out_valid && out_ready);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(distance_q16))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 16'd0)
		else $error("result without a pending input");

endmodule

bind haversine_distance_top hvd_chk u_hvd_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(points.valid),
	.in_ready(points.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.distance_q16(result.distance_q16)
);
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the haversine distance block with random traffic and back-pressure.
`timescale 1ns / 1ps
module tb_top;
	import hvd_pkg::*;

	// point pair as the input channel carries it
	typedef struct {
		logic signed [30:0] lat_a;
		logic signed [31:0] lon_a;
		logic signed [30:0] lat_b;
		logic signed [31:0] lon_b;
	} point_pair_t;

	localparam int  CORDIC_STEPS = 24;
	localparam int  DRAIN_CYCLES = 73 + 2 * CORDIC_STEPS + 40;
	localparam longint LAT_MAX   = 755914244;
	localparam longint LON_MAX   = 1509949440;
	localparam longint ONE_Q30   = 64'sd1 << 30;
	localparam longint ROT_GAIN  = 652032874;
	localparam longint PI_RAD    = 64'sd3373259426;
	localparam longint DEG90     = 1509949440;
	localparam longint DEG180    = 64'sd3019898880;
	localparam longint DEG360    = 64'sd6039797760;
	localparam longint ARCTAN [32] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
		64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
		64'h00000001, 64'h00000000
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [23:0] cfg_wdata;

	hvd_pt_if   pt_if ();
	hvd_dist_if dist_if ();

	haversine_distance_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.points    (pt_if),
		.result    (dist_if)
	);

	// stimulus and scoreboard state
	point_pair_t pending_pairs[$];
	logic [33:0] expected_dist[$];
	logic [23:0] radius_q8;
	int          fail_count;
	bit          jitter_on;
	bit          pt_taken;
	int          src_gap;
	int          sink_gap;
	int          sink_hold;

	// ---------------------------------------------------------------
	// Predictor: follows the block's fixed-point arithmetic exactly
	// ---------------------------------------------------------------
	function automatic longint q30_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned res;
		longint unsigned probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= res + probe) begin
				n -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	// Q24 degrees in [0, 90] to Q30 radians, rounded half up
	function automatic longint deg_to_q30(longint g);
		longint unsigned num;
		num = longint'(g) * PI_RAD + DEG180 / 2;
		return longint'(num / DEG180);
	endfunction

	// rotation CORDIC, returns sine and cosine of a Q30 angle
	function automatic void rotate(longint z, output longint sin_v, output longint cos_v);
		longint x, y, dx, dy;
		x = ROT_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		sin_v = y;
		cos_v = x;
	endfunction

	// vectoring CORDIC, angle of (x, y), clamped at zero
	function automatic longint arc_angle(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ARCTAN[i];
			end else begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end
		end
		return (z < 0) ? 0 : z;
	endfunction

	function automatic longint half_sine_sq(longint h);
		longint m, s, c;
		m = ((h % DEG180) + DEG180) % DEG180;
		if (m > DEG90)
			m = DEG180 - m;
		rotate(deg_to_q30(m), s, c);
		return q30_mul(s, s);
	endfunction

	function automatic longint cos_of_deg(longint g);
		longint m, s, c;
		bit flip;
		flip = 0;
		m = ((g % DEG360) + DEG360) % DEG360;
		if (m > DEG180)
			m = DEG360 - m;
		if (m > DEG90) begin
			flip = 1;
			m = DEG180 - m;
		end
		rotate(deg_to_q30(m), s, c);
		return flip ? -c : c;
	endfunction

	function automatic logic [33:0] predict_distance(point_pair_t p, logic [23:0] r);
		longint la, oa, lb, ob, u2, v2, cc, hav, s, c, theta;
		longint unsigned d;
		la = p.lat_a; oa = p.lon_a; lb = p.lat_b; ob = p.lon_b;
		u2 = half_sine_sq(lb - la);
		v2 = half_sine_sq(ob - oa);
		cc = q30_mul(cos_of_deg(la * 2), cos_of_deg(lb * 2));
		hav = u2 + q30_mul(cc, v2);
		if (hav < 0)
			hav = 0;
		if (hav > ONE_Q30)
			hav = ONE_Q30;
		s = longint'(floor_root(longint'(hav) << 30));
		c = longint'(floor_root((64'd1 << 60) - longint'(s * s)));
		theta = arc_angle(c, s);
		d = (longint'(r) * theta + (64'd1 << 20)) >> 21;
		return d[33:0];
	endfunction

	// ---------------------------------------------------------------
	// Clock and run limit
	// ---------------------------------------------------------------
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// Driver: presents queued pairs, random source bursts of idling
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!pt_if.valid || pt_taken)) begin
			pt_taken = 0;
			if (src_gap > 0) begin
				src_gap--;
				pt_if.valid <= 1'b0;
			end else if (pending_pairs.size() == 0) begin
				pt_if.valid <= 1'b0;
			end else if (jitter_on && $urandom_range(0, 7) == 0) begin
				src_gap = $urandom_range(0, 7);
				pt_if.valid <= 1'b0;
			end else begin
				point_pair_t p;
				p = pending_pairs.pop_front();
				pt_if.lat_a <= p.lat_a;
				pt_if.lon_a <= p.lon_a;
				pt_if.lat_b <= p.lat_b;
				pt_if.lon_b <= p.lon_b;
				pt_if.valid <= 1'b1;
			end
		end
	end

	// Result side ready: a long hold when asked, otherwise random bursts
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			dist_if.ready <= 1'b0;
		end else if (jitter_on && sink_gap > 0) begin
			sink_gap--;
			dist_if.ready <= 1'b0;
		end else if (jitter_on && $urandom_range(0, 7) == 0) begin
			sink_gap = $urandom_range(0, 7);
			dist_if.ready <= 1'b0;
		end else begin
			dist_if.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: predicts on each input transaction, checks each result
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && pt_if.valid && pt_if.ready) begin
			point_pair_t p;
			p.lat_a = pt_if.lat_a;
			p.lon_a = pt_if.lon_a;
			p.lat_b = pt_if.lat_b;
			p.lon_b = pt_if.lon_b;
			expected_dist.insert(expected_dist.size(), predict_distance(p, radius_q8));
			pt_taken = 1;
		end
		if (arst_n && dist_if.valid && dist_if.ready) begin
			if (expected_dist.size() == 0) begin
				$error("distance_q16: result with nothing expected, actual %0d",
					dist_if.distance_q16);
				fail_count++;
			end else begin
				logic [33:0] want;
				want = expected_dist.pop_front();
				if (dist_if.distance_q16 !== want) begin
					$error("distance_q16 mismatch: expected %0d, actual %0d",
						want, dist_if.distance_q16);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic point_pair_t make_pair(longint la, longint oa, longint lb, longint ob);
		point_pair_t p;
		p.lat_a = la[30:0];
		p.lon_a = oa[31:0];
		p.lat_b = lb[30:0];
		p.lon_b = ob[31:0];
		return p;
	endfunction

	// append a pair to the driver's queue
	function automatic void add_pair(point_pair_t p);
		pending_pairs.insert(pending_pairs.size(), p);
	endfunction

	function automatic longint rand_span(longint lim);
		return longint'($urandom_range(0, 32'(2 * lim))) - lim;
	endfunction

	// mostly legal coordinates, some with raw full-width bits
	function automatic point_pair_t random_pair();
		point_pair_t p;
		if ($urandom_range(0, 9) == 0) begin
			p.lat_a = 31'($urandom()); p.lon_a = $urandom();
			p.lat_b = 31'($urandom()); p.lon_b = $urandom();
		end else if ($urandom_range(0, 4) == 0) begin
			// nearby points, small differences
			longint la, oa;
			la = rand_span(LAT_MAX - 8000000);
			oa = rand_span(LON_MAX - 8000000);
			p = make_pair(la, oa, la + rand_span(4000000), oa + rand_span(4000000));
		end else begin
			p = make_pair(rand_span(LAT_MAX), rand_span(LON_MAX),
				rand_span(LAT_MAX), rand_span(LON_MAX));
		end
		return p;
	endfunction

	// radius writes only happen with the pipeline drained
	task automatic write_radius(logic [23:0] r);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		radius_q8 = r;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// poll after each rising edge so the driver and monitor have settled
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_pairs.size() != 0 || expected_dist.size() != 0 || pt_if.valid);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			add_pair(random_pair());
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pt_if.valid = 1'b0;
		pt_if.lat_a = '0; pt_if.lon_a = '0; pt_if.lat_b = '0; pt_if.lon_b = '0;
		dist_if.ready = 1'b0;
		radius_q8 = RADIUS_RESET;
		fail_count = 0;
		jitter_on = 1;
		pt_taken = 0;
		src_gap = 0;
		sink_gap = 0;
		sink_hold = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset radius, extremes and special cases
		add_pair(make_pair(0, 0, 0, 0));
		add_pair(make_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
		add_pair(make_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
		add_pair(make_pair(0, 0, 0, LON_MAX));          // antipodal on equator
		add_pair(make_pair(0, -LON_MAX, 0, LON_MAX));   // same point across the seam
		add_pair(make_pair(LAT_MAX, 0, -LAT_MAX, 0));   // pole to pole
		add_pair(make_pair(LAT_MAX, 123456789, LAT_MAX, -987654321));
		add_pair(make_pair(0, 0, 1, 1));                // tiny separation
		add_pair(make_pair(0, 0, 0, 2));
		add_pair(make_pair(LAT_MAX, 0, 0, 0));
		// latitudes beyond 90 degrees, can drive the argument below zero
		add_pair(make_pair(-(64'sd1 << 30), 0, (64'sd1 << 30) - 1, LON_MAX));
		add_pair(make_pair(1000000000, 0, 1000000000, LON_MAX));
		add_pair(make_pair(-1000000000, 300000000, 900000000, -1200000000));
		// full-width longitudes
		add_pair(make_pair(0, -(64'sd1 << 31), 0, (64'sd1 << 31) - 1));
		add_pair(make_pair((64'sd1 << 30) - 1, (64'sd1 << 31) - 1,
			-(64'sd1 << 30), -(64'sd1 << 31)));
		add_pair(make_pair(-1, -1, -1, -1));
		add_pair(make_pair(377957122, 754974720, -377957122, -754974720));
		wait_drained();

		// smallest radius
		write_radius(24'd1);
		add_pair(make_pair(0, 0, 0, LON_MAX));
		add_pair(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
		random_phase(60);

		// largest radius, with a long result-side hold so the input stalls
		write_radius(24'hFFFFFF);
		add_pair(make_pair(0, 0, 0, LON_MAX));
		sink_hold = 300;
		random_phase(200);

		// random radii, sender pauses for full drain between them
		for (int k = 0; k < 3; k++) begin
			write_radius(24'($urandom_range(1, 24'hFFFFFF)));
			random_phase(110);
		end

		write_radius(RADIUS_RESET);
		random_phase(120);

		// last stretch at full rate, no idling on either side
		jitter_on = 0;
		random_phase(220);

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
